>>> sv/fmbq_pkg.sv
// Shared types and constants for the front/middle/back queue.
`timescale 1ns / 1ps
package fmbq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int CMD_W     = 3;
  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT  = 3'd0,
    CMD_PUSH_MIDDLE = 3'd1,
    CMD_PUSH_BACK   = 3'd2,
    CMD_POP_FRONT   = 3'd3,
    CMD_POP_MIDDLE  = 3'd4,
    CMD_POP_BACK    = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Shift control broadcast to every cell
  typedef struct packed {
    logic ins;  // open a gap at pos and write the word there
    logic rem;  // close the gap at pos, cells above move down
  } cell_ctrl_t;

endpackage

>>> sv/front_middle_back_queue.sv
// Top level of the front/middle/back queue: command decode, count and result register.
//
// A bounded double-ended queue of signed 32-bit words that also inserts and
// removes at the middle. Input channel (in_valid/in_ready) carries cmd and
// data_value; output channel (out_valid/out_ready) returns status,
// popped_value and entry_count for every accepted command.
// Commands: push front/middle/back, pop front/middle/back. Middle push goes
// to index ceil(count/2) (back if count < 2); middle pop takes index
// ceil(count/2)-1 (front if count <= 2). Push on full and pop on empty are
// flagged and leave the queue untouched; codes 6 and 7 do nothing.
// Every word sits in a cell of a chain; all cells shift in the same cycle,
// and the result is registered on acceptance. Throughput: one command per
// cycle, set by the single output register, which may hold a result while
// the next command is taken.
// If the receiver stalls, in_ready drops once the result register is full.
// Reset clears the count and the output valid; stored words need no reset.
`timescale 1ns / 1ps
module front_middle_back_queue #(
  parameter int DEPTH = fmbq_pkg::DEPTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [fmbq_pkg::CMD_W-1:0]              cmd,
  input  logic signed [fmbq_pkg::DATA_W-1:0]      data_value,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [fmbq_pkg::STATUS_W-1:0]           status,
  output logic signed [fmbq_pkg::DATA_W-1:0]      popped_value,
  output logic [fmbq_pkg::COUNT_W-1:0]            entry_count
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int POS_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic                        accept;
  logic [CNT_W-1:0]            cnt;
  logic [CNT_W-1:0]            cnt_next;
  logic [CNT_W-1:0]            half_up;
  logic [POS_W-1:0]            pos;
  fmbq_pkg::cell_ctrl_t        ctrl;
  fmbq_pkg::status_t           status_next;
  logic signed [fmbq_pkg::DATA_W-1:0] popped_next;

  logic signed [fmbq_pkg::DATA_W-1:0] vals  [DEPTH];
  logic signed [fmbq_pkg::DATA_W-1:0] picks [DEPTH];

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // ceil(count/2)
  assign half_up = (cnt >> 1) + CNT_W'(cnt[0]);

  always_comb begin
    ctrl        = '0;
    pos         = '0;
    status_next = fmbq_pkg::ST_OK;
    cnt_next    = cnt;
    case (fmbq_pkg::cmd_t'(cmd))
      fmbq_pkg::CMD_PUSH_FRONT,
      fmbq_pkg::CMD_PUSH_MIDDLE,
      fmbq_pkg::CMD_PUSH_BACK: begin
        if (cnt == FULL_CNT) begin
          status_next = fmbq_pkg::ST_FULL;
        end else begin
          ctrl.ins = accept;
          cnt_next = cnt + CNT_W'(1);
          if (fmbq_pkg::cmd_t'(cmd) == fmbq_pkg::CMD_PUSH_FRONT) begin
            pos = '0;
          end else if (fmbq_pkg::cmd_t'(cmd) == fmbq_pkg::CMD_PUSH_BACK ||
                       cnt < CNT_W'(2)) begin
            pos = POS_W'(cnt);
          end else begin
            pos = POS_W'(half_up);
          end
        end
      end
      fmbq_pkg::CMD_POP_FRONT,
      fmbq_pkg::CMD_POP_MIDDLE,
      fmbq_pkg::CMD_POP_BACK: begin
        if (cnt == '0) begin
          status_next = fmbq_pkg::ST_EMPTY;
        end else begin
          ctrl.rem = accept;
          cnt_next = cnt - CNT_W'(1);
          if (fmbq_pkg::cmd_t'(cmd) == fmbq_pkg::CMD_POP_FRONT) begin
            pos = '0;
          end else if (fmbq_pkg::cmd_t'(cmd) == fmbq_pkg::CMD_POP_BACK) begin
            pos = POS_W'(cnt - CNT_W'(1));
          end else if (cnt <= CNT_W'(2)) begin
            pos = '0;
          end else begin
            pos = POS_W'(half_up - CNT_W'(1));
          end
        end
      end
      default: begin
        // unused codes leave everything as it is
      end
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic signed [fmbq_pkg::DATA_W-1:0] lower;
      logic signed [fmbq_pkg::DATA_W-1:0] upper;
      if (gi == 0) begin : g_first
        assign lower = data_value;
      end else begin : g_lower
        assign lower = vals[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign upper = vals[gi];
      end else begin : g_upper
        assign upper = vals[gi+1];
      end
      fmbq_cell #(
        .POS_W (POS_W),
        .IDX   (gi)
      ) u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .pos         (pos),
        .data_value  (data_value),
        .lower_value (lower),
        .upper_value (upper),
        .value       (vals[gi]),
        .pick        (picks[gi])
      );
    end
  endgenerate

  always_comb begin
    popped_next = '0;
    for (int i = 0; i < DEPTH; i++) begin
      popped_next = popped_next | picks[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        cnt       <= cnt_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status       <= status_next;
      popped_value <= popped_next;
      entry_count  <= fmbq_pkg::COUNT_W'(cnt_next);
    end
  end

  // count stays within the chain
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt <= FULL_CNT)
    else $error("count beyond depth");

  // push on full is flagged and leaves the count alone
  a_push_full: assert property (@(posedge clk) disable iff (rst)
    accept && cnt == FULL_CNT && cmd <= fmbq_pkg::CMD_W'(fmbq_pkg::CMD_PUSH_BACK)
    |=> status == fmbq_pkg::ST_FULL && $stable(cnt))
    else $error("push on full not flagged");

  // pop on empty is flagged and returns zero
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    accept && cnt == '0 &&
    (cmd == fmbq_pkg::CMD_W'(fmbq_pkg::CMD_POP_FRONT) ||
     cmd == fmbq_pkg::CMD_W'(fmbq_pkg::CMD_POP_MIDDLE) ||
     cmd == fmbq_pkg::CMD_W'(fmbq_pkg::CMD_POP_BACK))
    |=> status == fmbq_pkg::ST_EMPTY && popped_value == '0)
    else $error("pop on empty not flagged");

  // reported count matches the stored count
  a_count_out: assert property (@(posedge clk) disable iff (rst)
    accept |=> entry_count == fmbq_pkg::COUNT_W'(cnt))
    else $error("entry_count out of step");

  // no word accepted, no change in count
  a_cnt_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(cnt))
    else $error("count moved without a word");

endmodule

>>> sv/fmbq_cell.sv
// One storage cell of the queue chain: holds one word, shifts left or right.
`timescale 1ns / 1ps
module fmbq_cell #(
  parameter int POS_W = 4,
  parameter int IDX   = 0
) (
  input  logic                                 clk,
  input  fmbq_pkg::cell_ctrl_t                 ctrl,
  input  logic [POS_W-1:0]                     pos,
  input  logic signed [fmbq_pkg::DATA_W-1:0]   data_value,
  input  logic signed [fmbq_pkg::DATA_W-1:0]   lower_value,
  input  logic signed [fmbq_pkg::DATA_W-1:0]   upper_value,
  output logic signed [fmbq_pkg::DATA_W-1:0]   value,
  output logic signed [fmbq_pkg::DATA_W-1:0]   pick
);

  localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

  logic signed [fmbq_pkg::DATA_W-1:0] value_next;
  logic                               at_pos;
  logic                               above_pos;

  assign at_pos    = (pos == MY_POS);
  assign above_pos = (MY_POS > pos);

  always_comb begin
    value_next = value;
    if (ctrl.ins) begin
      if (at_pos) begin
        value_next = data_value;
      end else if (above_pos) begin
        value_next = lower_value;
      end
    end else if (ctrl.rem) begin
      if (at_pos || above_pos) begin
        value_next = upper_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

  // word leaving the chain on a pop, zero elsewhere so the top can OR them
  assign pick = (ctrl.rem && at_pos) ? value : '0;

endmodule
